### src/lcg_pkg.sv
// Package with the sequencer states and register constants of the linear congruential generator.
package lcg_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned CntW  = 6;

  typedef logic [DataW-1:0] data_t;

  typedef enum logic [1:0] {
    REG_MULTIPLIER = 2'd0,
    REG_INCREMENT  = 2'd1,
    REG_MODULUS    = 2'd2,
    REG_SEED       = 2'd3
  } reg_idx_e;

  localparam data_t MultiplierRst = 64'd16807;
  localparam data_t IncrementRst  = 64'd0;
  localparam data_t ModulusRst    = 64'd2147483647;
  localparam data_t SeedRst       = 64'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_MUL,
    ST_CHK_INC,
    ST_CHK_SEED,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

### src/linear_congruential_generator.sv
// Linear congruential generator with a configurable 64-bit modulus.
//
// Registers are written through cfg_we_i, cfg_idx_i and cfg_data_i: multiplier,
// increment, modulus and seed. The user must write them only while the block is
// idle; the block itself does not enforce this. Each request transfer on the input
// channel (in_valid_i, in_stall_o, restart_i) produces exactly one result transfer
// on the output channel (out_valid_o, out_stall_i, value_o, config_error_o). A set
// restart_i reloads the state from the seed first. A request runs through three
// compare steps, 64 shift-and-add multiply steps, one add of the increment,
// 64 restoring remainder steps and a final step that loads the output register,
// all through one shared 65-bit adder. In the meantime in_stall_o stays high, so
// a new request is taken only after the previous one has finished. An invalid
// configuration skips the arithmetic and goes from the compare steps to the output.
// The result sits in an output register; while the receiver stalls it holds,
// and a finished computation waits until the register is free.
// Reset restores the register reset values, loads the state with the reset
// seed and empties the output register.
module linear_congruential_generator
  import lcg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [DataW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             restart_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DataW-1:0] value_o,
  output logic             config_error_o
);

  state_e state_q, state_d;

  data_t mul_q, inc_q, mod_q, seed_q, cur_q, cur_d;
  data_t acc_q, acc_d, mcand_q, mcand_d, mplier_q, mplier_d, rem_q, rem_d;
  data_t value_q, value_d;
  logic  [CntW-1:0] cnt_q, cnt_d;
  logic  bad_q, bad_d;
  logic  out_valid_q, out_valid_d, err_q, err_d;

  logic [DataW:0]   op_a, op_b;
  logic             op_cin;
  logic [DataW+1:0] sum;
  logic [DataW:0]   trial;
  logic             geq;
  logic             in_xfer, out_free, cnt_last;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign cnt_last = (cnt_q == {CntW{1'b1}});
  assign trial    = {rem_q, acc_q[DataW-1]};

  assign sum = {1'b0, op_a} + {1'b0, op_b} + {{(DataW+1){1'b0}}, op_cin};
  assign geq = sum[DataW+1];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_xfer) state_d = ST_CHK_MUL;
      ST_CHK_MUL:  state_d = ST_CHK_INC;
      ST_CHK_INC:  state_d = ST_CHK_SEED;
      ST_CHK_SEED: state_d = (bad_q || geq) ? ST_OUT : ST_MUL;
      ST_MUL:      if (cnt_last) state_d = ST_ADD;
      ST_ADD:      state_d = ST_DIV;
      ST_DIV:      if (cnt_last) state_d = ST_OUT;
      ST_OUT:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    op_a       = {1'b0, acc_q};
    op_b       = {1'b0, mcand_q};
    op_cin     = 1'b0;
    unique case (state_q)
      ST_CHK_MUL: begin
        op_a   = {1'b0, mul_q};
        op_b   = ~{1'b0, mod_q};
        op_cin = 1'b1;
      end
      ST_CHK_INC: begin
        op_a   = {1'b0, inc_q};
        op_b   = ~{1'b0, mod_q};
        op_cin = 1'b1;
      end
      ST_CHK_SEED: begin
        op_a   = {1'b0, seed_q};
        op_b   = ~{1'b0, mod_q};
        op_cin = 1'b1;
      end
      ST_ADD: begin
        op_b = {1'b0, inc_q};
      end
      ST_DIV: begin
        op_a   = trial;
        op_b   = ~{1'b0, mod_q};
        op_cin = 1'b1;
      end
      default: begin
        op_a = {1'b0, acc_q};
      end
    endcase
  end

  always_comb begin
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    bad_d       = bad_q;
    cur_d       = cur_q;
    value_d     = value_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          acc_d    = '0;
          mcand_d  = mul_q;
          mplier_d = restart_i ? seed_q : cur_q;
          rem_d    = '0;
          cnt_d    = '0;
          bad_d    = 1'b0;
        end
      end
      ST_CHK_MUL, ST_CHK_INC, ST_CHK_SEED: begin
        bad_d = bad_q || geq;
      end
      ST_MUL: begin
        if (mplier_q[0]) acc_d = sum[DataW-1:0];
        mcand_d  = {mcand_q[DataW-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[DataW-1:1]};
        cnt_d    = cnt_q + 1'b1;
      end
      ST_ADD: begin
        acc_d = sum[DataW-1:0];
      end
      ST_DIV: begin
        rem_d = geq ? sum[DataW-1:0] : trial[DataW-1:0];
        acc_d = {acc_q[DataW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          err_d       = bad_q;
          value_d     = bad_q ? '0 : rem_q;
          if (!bad_q) cur_d = rem_q;
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mul_q       <= MultiplierRst;
      inc_q       <= IncrementRst;
      mod_q       <= ModulusRst;
      seed_q      <= SeedRst;
      cur_q       <= SeedRst;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      bad_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      bad_q       <= bad_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_MULTIPLIER: mul_q  <= cfg_data_i;
          REG_INCREMENT:  inc_q  <= cfg_data_i;
          REG_MODULUS:    mod_q  <= cfg_data_i;
          REG_SEED:       seed_q <= cfg_data_i;
          default:        mul_q  <= mul_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    rem_q    <= rem_d;
    value_q  <= value_d;
    err_q    <= err_d;
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = value_q;
  assign config_error_o = err_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && config_error_o |-> value_o == '0)
    else $error("Error result carries a nonzero value.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && state_q == ST_CHK_MUL)
    else $error("Sequencer did not start after a request transfer.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < mod_q)
    else $error("Partial remainder reached the modulus.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !config_error_o |-> value_o < mod_q)
    else $error("Generated value is not below the modulus.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT && out_valid_q && out_stall_i |=> state_q == ST_OUT)
    else $error("Result left the sequencer while the output register was held.");

endmodule
